// ----- rtl/rar4_pkg.sv -----
package rar4_pkg;

    // tally width, saturating counter of file headers
    localparam int COUNT_BITS = 16;
    localparam int FOUND_BITS = 16;
    localparam int POS_BITS   = 33;

    // block types
    localparam logic [7:0] KIND_MAIN = 8'h73;
    localparam logic [7:0] KIND_FILE = 8'h74;
    localparam logic [7:0] KIND_END  = 8'h7B;

    // fixed offsets inside a block
    localparam int NAME_OFFSET     = 32;
    localparam int FILE_FIXED_SPAN = 28;
    localparam int MIN_HEAD        = 7;
    localparam int SIG_LEN         = 7;

    // walk status codes
    localparam logic [2:0] ST_CLEAN     = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_END_MARK  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    // result kinds
    localparam logic RK_NAME    = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_SIG   = 3'b001,
        PH_BLOCK = 3'b010,
        PH_STOP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [7:0]            name_char;
        logic                  name_end;
        logic [FOUND_BITS-1:0] files_found;
        logic [2:0]            walk_status;
        logic                  last_result;
    } res_item_t;

    // archive signature bytes
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h52;
            3'd1:    val = 8'h61;
            3'd2:    val = 8'h72;
            3'd3:    val = 8'h21;
            3'd4:    val = 8'h1A;
            3'd5:    val = 8'h07;
            3'd6:    val = 8'h00;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/rar4_walk_core.sv -----
module rar4_walk_core import rar4_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  in_item_t  in_item,
    output logic [1:0] push_cnt,
    output res_item_t res0,
    output res_item_t res1
);

    phase_t                phase_reg, phase_next;
    logic [2:0]            sidx_reg, sidx_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [7:0]            kind_reg, kind_next;
    logic [15:0]           hlen_reg, hlen_next;
    logic [31:0]           plen_reg, plen_next;
    logic [15:0]           nlen_reg, nlen_next;
    logic [COUNT_BITS-1:0] tally_reg, tally_next;
    logic [2:0]            stop_reg, stop_next;

    logic [7:0]            b;
    logic                  last;
    logic                  emit;
    logic                  fin;
    logic                  done;
    logic [2:0]            status;
    logic [POS_BITS-1:0]   rel;
    logic [POS_BITS:0]     p_plus;
    logic [POS_BITS:0]     span;
    logic [1:0]            lane;
    res_item_t             name_res;
    res_item_t             summ_res;

    assign b    = in_item.data_byte;
    assign last = in_item.end_of_data;

    // next state and result selection for one byte
    always_comb begin
        phase_next = phase_reg;
        sidx_next  = sidx_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        hlen_next  = hlen_reg;
        plen_next  = plen_reg;
        nlen_next  = nlen_reg;
        tally_next = tally_reg;
        stop_next  = stop_reg;
        emit       = 1'b0;
        fin        = 1'b0;
        done       = 1'b0;
        rel        = pos_reg - POS_BITS'(NAME_OFFSET);
        p_plus     = {1'b0, pos_reg} + (POS_BITS+1)'(1);
        span       = '0;
        lane       = 2'(pos_reg - POS_BITS'(7));

        unique case (phase_reg)
            PH_SIG: begin
                if (sidx_reg != 3'(SIG_LEN) && b == sig_byte(sidx_reg)) begin
                    sidx_next = sidx_reg + 3'd1;
                    if (sidx_reg == 3'(SIG_LEN - 1)) begin
                        phase_next = PH_BLOCK;
                        pos_next   = '0;
                    end
                end else begin
                    phase_next = PH_STOP;
                    stop_next  = ST_BAD_SIG;
                end
            end
            PH_BLOCK: begin
                // header field capture
                if (pos_reg == '0) begin
                    kind_next = '0;
                    hlen_next = '0;
                    plen_next = '0;
                    nlen_next = '0;
                end else if (pos_reg == POS_BITS'(2)) begin
                    kind_next = b;
                    if (b == KIND_END) begin
                        phase_next = PH_STOP;
                        stop_next  = ST_END_MARK;
                    end else if (b != KIND_MAIN && b != KIND_FILE) begin
                        phase_next = PH_STOP;
                        stop_next  = ST_UNKNOWN;
                    end
                end else if (pos_reg == POS_BITS'(5)) begin
                    hlen_next = {8'h00, b};
                end else if (pos_reg == POS_BITS'(6)) begin
                    hlen_next = {b, hlen_reg[7:0]};
                    if (hlen_next < 16'(MIN_HEAD)) begin
                        phase_next = PH_STOP;
                        stop_next  = ST_BAD_SIZE;
                    end else if (kind_reg == KIND_FILE && tally_reg != '1) begin
                        tally_next = tally_reg + COUNT_BITS'(1);
                    end
                end

                // file header fields and name bytes
                if (phase_next == PH_BLOCK && kind_next == KIND_FILE) begin
                    if (pos_reg >= POS_BITS'(7) && pos_reg <= POS_BITS'(10)) begin
                        plen_next[8*lane +: 8] = plen_reg[8*lane +: 8] | b;
                    end else if (pos_reg == POS_BITS'(26)) begin
                        nlen_next = {8'h00, b};
                    end else if (pos_reg == POS_BITS'(27)) begin
                        nlen_next = {b, nlen_reg[7:0]};
                    end else if (pos_reg >= POS_BITS'(NAME_OFFSET)
                                 && pos_reg < POS_BITS'(hlen_next)
                                 && rel < POS_BITS'(nlen_next)) begin
                        emit = 1'b1;
                        fin  = (rel == POS_BITS'(nlen_next) - POS_BITS'(1))
                            || (pos_reg == POS_BITS'(hlen_next) - POS_BITS'(1));
                    end
                end

                // block end and position advance
                if (phase_next == PH_BLOCK) begin
                    span = (POS_BITS+1)'(hlen_next) + (POS_BITS+1)'(plen_next);
                    if (kind_next == KIND_MAIN && pos_reg >= POS_BITS'(6)) begin
                        done = p_plus >= (POS_BITS+1)'(hlen_next);
                    end else if (kind_next == KIND_FILE
                                 && p_plus >= (POS_BITS+1)'(FILE_FIXED_SPAN)) begin
                        done = p_plus >= span;
                    end
                    pos_next = done ? '0 : p_plus[POS_BITS-1:0];
                end
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase

        // summary status from the state this byte leaves
        if (phase_next == PH_STOP) begin
            status = stop_next;
        end else if (phase_next == PH_BLOCK && pos_next == '0) begin
            status = ST_CLEAN;
        end else begin
            status = ST_TRUNCATED;
        end
    end

    // result items
    always_comb begin
        name_res             = '0;
        name_res.result_kind = RK_NAME;
        name_res.name_char   = b;
        name_res.name_end    = fin;
        name_res.last_result = !last;

        summ_res             = '0;
        summ_res.result_kind = RK_SUMMARY;
        summ_res.files_found = FOUND_BITS'(tally_next);
        summ_res.walk_status = status;
        summ_res.last_result = 1'b1;

        res0     = emit ? name_res : summ_res;
        res1     = summ_res;
        push_cnt = in_fire ? (2'(emit) + 2'(last)) : 2'd0;
    end

    // state registers, back to reset after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && last)) begin
            phase_reg <= PH_SIG;
            sidx_reg  <= '0;
            pos_reg   <= '0;
            kind_reg  <= '0;
            hlen_reg  <= '0;
            plen_reg  <= '0;
            nlen_reg  <= '0;
            tally_reg <= '0;
            stop_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            sidx_reg  <= sidx_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            hlen_reg  <= hlen_next;
            plen_reg  <= plen_next;
            nlen_reg  <= nlen_next;
            tally_reg <= tally_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

// ----- rtl/rar4_res_fifo.sv -----
module rar4_res_fifo import rar4_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  res_item_t  res0,
    input  res_item_t  res1,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output res_item_t  m_data
);

    res_item_t  mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_plus;

    // room for two results regardless of this cycle's pop
    assign room    = count_reg <= 3'd2;
    assign m_valid = count_reg != 3'd0;
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    assign wr_ptr_plus = wr_ptr_reg + 2'd1;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(push_cnt) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, one or two writes per transaction
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus] <= res1;
        end
    end

endmodule

// ----- rtl/rar4_header_walker.sv -----
// archive header walker: one byte per cycle on the s_ side
// results: each result is registered in the queue when the byte that causes it is taken, and leaves on m_ in order
// throughput: one byte per cycle, one result per cycle out of a four-entry queue;
// a byte waits only while the queue lacks room for two results
// reset: synchronous active-low aresetn clears the walk state and empties the queue
module rar4_header_walker import rar4_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output res_item_t m_data
);

    logic       in_fire;
    logic       room;
    logic [1:0] push_cnt;
    res_item_t  res0;
    res_item_t  res1;

    // input transaction when the queue can take two results
    assign s_ready = room;
    assign in_fire = s_valid && room;

    rar4_walk_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_item  (s_data),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    rar4_res_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
